// ===== hw/rtl/lmph_pkg.sv =====
// Shared types and constants for the level meter with peak hold.
// No dependencies; compiled first.
package lmph_pkg;

	localparam int NUM_CHANNELS_DEF = 16;
	localparam int CHANNEL_W        = 4;
	localparam int LEVEL_W          = 8;
	localparam int REG_IDX_W        = 2;

	typedef logic [LEVEL_W-1:0]   level_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	// Configuration register indexes
	localparam reg_idx_t REG_HOLD_RELOAD      = reg_idx_t'(0);
	localparam reg_idx_t REG_PEAK_DECAY_STEP  = reg_idx_t'(1);
	localparam reg_idx_t REG_MIN_RELEASE_STEP = reg_idx_t'(2);

	// Register reset values
	localparam level_t HOLD_RELOAD_RST      = level_t'(8);
	localparam level_t PEAK_DECAY_STEP_RST  = level_t'(3);
	localparam level_t MIN_RELEASE_STEP_RST = level_t'(4);

	typedef struct packed {
		logic [CHANNEL_W-1:0] channel;
		level_t               raw_level;
		logic                 level_valid;
		logic                 end_of_frame;
	} in_item_t;

	typedef struct packed {
		level_t shown_level;
		level_t peak_level;
		logic   channel_changed;
		logic   frame_changed;
	} out_item_t;

	typedef struct packed {
		reg_idx_t reg_index;
		level_t   wr_data;
	} cfg_wr_t;

	// One channel entry of the meter store
	typedef struct packed {
		level_t level;
		level_t peak;
		level_t hold;
	} meter_entry_t;

endpackage

// ===== hw/rtl/lmph_chan_if.sv =====
// Valid/ready channel carrying one payload struct per transaction.
// Payload types come from lmph_pkg.
interface lmph_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/level_meter_peak_hold.sv =====
// Level meter with peak hold: per-channel ballistics kept in one channel-indexed memory.
// Depends on lmph_pkg and lmph_chan_if.
//
// Channel  Dir  Payload                                                   Transaction
// in       in   channel, raw_level, level_valid, end_of_frame             valid & ready
// out      out  shown_level, peak_level, channel_changed, frame_changed   valid & ready
// cfg      in   reg_index, wr_data                                        valid & ready
//
// One transaction per cycle sustained while the output is not stalled. An item is read
// from the meter memory when it is accepted; when the update stage advances it is
// updated, written back and loaded into the output register that drives out.valid.
// The single read-modify-write loop through the memory sets that rate; a same-channel
// item right behind takes the written value by forwarding.
// Reset clears control state and per-entry valid bits and loads the config registers'
// reset values, so the store reads as zero at once; no clearing pass is needed.
// A stalled output holds the update stage, which in turn holds in.ready low.
module level_meter_peak_hold #(
	parameter int NUM_CHANNELS = lmph_pkg::NUM_CHANNELS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	lmph_chan_if.sink   in,
	lmph_chan_if.source out,
	lmph_chan_if.sink   cfg
);
	import lmph_pkg::*;

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [8:0] NUM_CH_W = 9'(NUM_CHANNELS);

	// ---------------------------------------------------------------- config
	level_t hold_reload_q;
	level_t peak_decay_step_q;
	level_t min_release_step_q;

	assign cfg.ready = 1'b1;

	// Write only the listed registers; drop writes beyond the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_reload_q      <= HOLD_RELOAD_RST;
			peak_decay_step_q  <= PEAK_DECAY_STEP_RST;
			min_release_step_q <= MIN_RELEASE_STEP_RST;
		end else if (cfg.valid) begin
			case (cfg.data.reg_index)
				REG_HOLD_RELOAD:      hold_reload_q      <= cfg.data.wr_data;
				REG_PEAK_DECAY_STEP:  peak_decay_step_q  <= cfg.data.wr_data;
				REG_MIN_RELEASE_STEP: min_release_step_q <= cfg.data.wr_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- handshake
	logic      valid_s1;
	logic      out_valid_q;
	out_item_t out_data_q;
	logic      adv_s1;
	logic      in_fire;

	// Advance the update stage whenever the output register is free or being taken.
	assign adv_s1   = valid_s1 && (!out_valid_q || out.ready);
	assign in.ready = !valid_s1 || adv_s1;
	assign in_fire  = in.valid && in.ready;

	// ---------------------------------------------------------------- decode
	logic [8:0]    chan_ext;
	logic [AW-1:0] in_addr;
	logic          in_range;
	level_t        in_goal;

	assign chan_ext = 9'(in.data.channel);
	assign in_addr  = chan_ext[AW-1:0];
	assign in_range = chan_ext < NUM_CH_W;
	// An invalid level counts as a target of zero.
	assign in_goal  = in.data.level_valid ? in.data.raw_level : '0;

	// ---------------------------------------------------------------- memory
	meter_entry_t            mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] ent_vld_q;

	logic [AW-1:0] addr_s1;
	logic          in_range_s1;
	level_t        goal_s1;
	logic          eof_s1;
	meter_entry_t  rd_s1;
	logic          ent_vld_s1;
	logic          fwd_s1;
	meter_entry_t  fwd_data_s1;

	logic          wr_en;
	meter_entry_t  new_ent;

	assign wr_en = adv_s1 && in_range_s1;

	// Registered read at accept; write back when the update stage advances.
	always_ff @(posedge clk) begin
		if (in_fire && in_range) begin
			rd_s1 <= mem[in_addr];
		end
		if (wr_en) begin
			mem[addr_s1] <= new_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr_en) begin
			ent_vld_q[addr_s1] <= 1'b1;
		end
	end

	// Stage 1 item; capture forwarding when the entry being written is the one read now.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
			fwd_s1   <= wr_en && (addr_s1 == in_addr);
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_s1     <= in_addr;
			in_range_s1 <= in_range;
			goal_s1     <= in_goal;
			eof_s1      <= in.data.end_of_frame;
			ent_vld_s1  <= in_range ? ent_vld_q[in_addr] : 1'b0;
			fwd_data_s1 <= new_ent;
		end
	end

	// ---------------------------------------------------------------- update
	meter_entry_t old_ent;
	level_t       gap;
	level_t       half_gap;
	level_t       drop;
	level_t       shown;
	level_t       peak;
	level_t       hold;
	logic         changed;
	logic         frame;
	logic         acc_q;

	always_comb begin
		if (fwd_s1) begin
			old_ent = fwd_data_s1;
		end else if (ent_vld_s1) begin
			old_ent = rd_s1;
		end else begin
			old_ent = '0;
		end

		// Attack is instant; release falls by max(gap/2, min step), never past target.
		gap      = old_ent.level - goal_s1;
		half_gap = gap >> 1;
		drop     = (half_gap < min_release_step_q) ? min_release_step_q : half_gap;
		if (goal_s1 >= old_ent.level) begin
			shown = goal_s1;
		end else if (drop >= gap) begin
			shown = goal_s1;
		end else begin
			shown = old_ent.level - drop;
		end

		// Peak follows upward and reloads the hold; after the hold, decay to zero.
		peak = old_ent.peak;
		hold = old_ent.hold;
		if (shown >= old_ent.peak) begin
			peak = shown;
			hold = hold_reload_q;
		end else if (old_ent.hold != '0) begin
			hold = old_ent.hold - 8'd1;
		end else if (old_ent.peak > peak_decay_step_q) begin
			peak = old_ent.peak - peak_decay_step_q;
		end else begin
			peak = '0;
		end

		new_ent.level = shown;
		new_ent.peak  = peak;
		new_ent.hold  = hold;

		changed = in_range_s1 && ((shown != old_ent.level) || (peak != old_ent.peak));
		frame   = acc_q | changed;
	end

	// Frame change accumulator; clear after the end-of-frame item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 1'b0;
		end else if (adv_s1) begin
			acc_q <= eof_s1 ? 1'b0 : frame;
		end
	end

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Out-of-range channels report zero level and peak.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q.shown_level     <= in_range_s1 ? shown : '0;
			out_data_q.peak_level      <= in_range_s1 ? peak : '0;
			out_data_q.channel_changed <= changed;
			out_data_q.frame_changed   <= frame;
		end
	end

	assign out.valid = out_valid_q;
	assign out.data  = out_data_q;

	// ---------------------------------------------------------------- checks
	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forwarding flag set with no item in the update stage");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(addr_s1) && $stable(goal_s1)))
		else $error("update stage item changed while stalled");

	a_frame_covers_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.channel_changed) |-> out_data_q.frame_changed)
		else $error("channel change not reflected in frame change");

	a_eof_clears_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && eof_s1) |=> !acc_q)
		else $error("frame accumulator not cleared after end of frame");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for level_meter_peak_hold: a directed table, then random frames
// and bursts, checked against an in-bench predictor of the meter ballistics.
// Depends on lmph_pkg, lmph_chan_if and the level_meter_peak_hold RTL.
module testbench;
	import lmph_pkg::*;

	localparam int          NUM_METERS   = 16;
	localparam int          RANDOM_ITEMS = 200;	// per random phase
	localparam int          NUM_PHASES   = 7;
	localparam int          QUIET_LIMIT  = 1000;	// cycles with no transaction at all
	localparam int          TAIL_CYCLES  = 8;	// margin after the last result
	localparam reg_idx_t    REG_SPARE    = reg_idx_t'(3);	// unmapped index, must be ignored

	// One row of the directed table: either a register write or a channel update,
	// the latter optionally with a result typed in by hand.
	typedef struct {
		bit        is_write;
		cfg_wr_t   wr;
		in_item_t  item;
		bit        pinned;
		out_item_t want;
	} meter_step_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	lmph_chan_if #(.payload_t(in_item_t))  in_ch  ();
	lmph_chan_if #(.payload_t(out_item_t)) out_ch ();
	lmph_chan_if #(.payload_t(cfg_wr_t))   cfg_ch ();

	level_meter_peak_hold #(.NUM_CHANNELS(NUM_METERS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: its own copy of the meter store and the registers.
	level_t shown_mem [NUM_METERS];
	level_t peak_mem  [NUM_METERS];
	level_t hold_mem  [NUM_METERS];
	logic   frame_acc;
	level_t hold_reload;
	level_t peak_decay_step;
	level_t min_release_step;

	out_item_t   pending_readings[$];	// predicted results, oldest first
	int          mismatch_count = 0;
	int unsigned feed_idle_max  = 3;	// largest gap before each update
	int unsigned sink_idle_max  = 3;	// largest stall before each result
	logic        pin_flag;		// item on the bus carries a hand-typed result
	out_item_t   pin_reading;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Advance the predicted meter by one update and return the reading it shows.
	function automatic out_item_t advance_meter(in_item_t it);
		level_t      target;
		level_t      old_level;
		level_t      old_peak;
		level_t      gap;
		level_t      fall;
		out_item_t   r;
		r         = '0;
		target    = it.level_valid ? it.raw_level : '0;
		old_level = shown_mem[it.channel];
		old_peak  = peak_mem[it.channel];
		// Attack is instant; release drops by half the gap, at least the minimum
		// step, and never overshoots the target.
		if (target >= old_level) begin
			r.shown_level = target;
		end else begin
			gap  = old_level - target;
			fall = gap >> 1;
			if (fall < min_release_step) begin
				fall = min_release_step;
			end
			r.shown_level = (fall >= gap) ? target : level_t'(old_level - fall);
		end
		// Peak follows upward and reloads the hold; after the hold, decay to zero.
		r.peak_level = old_peak;
		if (r.shown_level >= old_peak) begin
			r.peak_level          = r.shown_level;
			hold_mem[it.channel]  = hold_reload;
		end else if (hold_mem[it.channel] != 0) begin
			hold_mem[it.channel]  = hold_mem[it.channel] - 1'b1;
		end else begin
			r.peak_level = (old_peak > peak_decay_step) ? level_t'(old_peak - peak_decay_step)
			                                            : '0;
		end
		shown_mem[it.channel] = r.shown_level;
		peak_mem[it.channel]  = r.peak_level;
		// Hold count alone never counts as a change.
		r.channel_changed = (r.shown_level != old_level) || (r.peak_level != old_peak);
		r.frame_changed   = frame_acc | r.channel_changed;
		frame_acc         = it.end_of_frame ? 1'b0 : r.frame_changed;
		return r;
	endfunction

	function automatic int unsigned draw_wait(int unsigned max_wait);
		return (max_wait == 0) ? 0 : $urandom_range(0, max_wait);
	endfunction

	// Favor silence, full scale and the bottom and top of the range.
	function automatic level_t draw_level();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return level_t'($urandom_range(0, 15));
			4: return level_t'($urandom_range(240, 255));
			default: return level_t'($urandom);
		endcase
	endfunction

	function automatic in_item_t meter_item(int ch, level_t raw, bit lvl_valid, bit eof);
		in_item_t it;
		it.channel      = ch[CHANNEL_W-1:0];
		it.raw_level    = raw;
		it.level_valid  = lvl_valid;
		it.end_of_frame = eof;
		return it;
	endfunction

	function automatic meter_step_t item_step(int ch, level_t raw, bit lvl_valid, bit eof);
		meter_step_t s;
		s          = '{default: '0};
		s.item     = meter_item(ch, raw, lvl_valid, eof);
		return s;
	endfunction

	function automatic meter_step_t pinned_step(int ch, level_t raw, bit lvl_valid, bit eof,
	                                            level_t shown, level_t peak, bit chg, bit frm);
		meter_step_t s;
		s                      = item_step(ch, raw, lvl_valid, eof);
		s.pinned               = 1'b1;
		s.want.shown_level     = shown;
		s.want.peak_level      = peak;
		s.want.channel_changed = chg;
		s.want.frame_changed   = frm;
		return s;
	endfunction

	function automatic meter_step_t write_step(reg_idx_t idx, level_t value);
		meter_step_t s;
		s              = '{default: '0};
		s.is_write     = 1'b1;
		s.wr.reg_index = idx;
		s.wr.wr_data   = value;
		return s;
	endfunction

	// Offer one update after a random gap and hold it until the meter takes it.
	task automatic send_update(in_item_t it, bit pinned, out_item_t want);
		int unsigned gap;
		gap = draw_wait(feed_idle_max);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		pin_flag    <= pinned;
		pin_reading <= want;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
	endtask

	// Stop feeding and wait until every predicted result has come back.
	task automatic hold_feed_until_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_readings.size() != 0);
	endtask

	// Registers change only on an idle meter: drain first, then write.
	task automatic write_register(reg_idx_t idx, level_t value);
		hold_feed_until_drained();
		cfg_ch.valid          <= 1'b1;
		cfg_ch.data.reg_index <= idx;
		cfg_ch.data.wr_data   <= value;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		cfg_ch.valid <= 1'b0;
	endtask

	// Random traffic in one register setting: mostly frames that sweep the bands
	// in order and end with end_of_frame, some same-channel bursts to hit the
	// forwarding path, and a little noise with random channels and frame marks.
	task automatic run_random_phase(int n_items, bit pause_midway);
		int        sent;
		int        len;
		int        ch;
		int        burst;
		bit        paused;
		out_item_t none;
		sent   = 0;
		paused = 1'b0;
		none   = '0;
		while (sent < n_items) begin
			if (pause_midway && !paused && sent >= n_items / 2) begin
				hold_feed_until_drained();
				paused = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: begin
					len = $urandom_range(1, NUM_METERS);
					for (int i = 0; i < len; i++) begin
						send_update(meter_item(i, draw_level(), $urandom_range(0, 7) != 0,
						                       i == len - 1), 1'b0, none);
					end
					sent += len;
				end
				7, 8: begin
					ch    = $urandom_range(0, NUM_METERS - 1);
					burst = $urandom_range(2, 6);
					for (int i = 0; i < burst; i++) begin
						send_update(meter_item(ch, draw_level(), $urandom_range(0, 5) != 0,
						                       $urandom_range(0, 7) == 0), 1'b0, none);
					end
					sent += burst;
				end
				default: begin
					send_update(meter_item($urandom_range(0, NUM_METERS - 1), level_t'($urandom),
					                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
					            1'b0, none);
					sent++;
				end
			endcase
		end
	endtask

	// Scoreboard: track register writes, predict on every accepted update and
	// check every accepted result against the oldest prediction.
	always @(posedge clk) begin : scoreboard
		out_item_t predicted;
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.data.reg_index)
					REG_HOLD_RELOAD:      hold_reload      = cfg_ch.data.wr_data;
					REG_PEAK_DECAY_STEP:  peak_decay_step  = cfg_ch.data.wr_data;
					REG_MIN_RELEASE_STEP: min_release_step = cfg_ch.data.wr_data;
					default: ;	// unmapped index: no effect
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (pending_readings.size() == 0) begin
					report_mismatch("result with nothing outstanding", got.shown_level, 0);
				end else begin
					want = pending_readings.pop_front();
					if (got.shown_level != want.shown_level)
						report_mismatch("shown_level", got.shown_level, want.shown_level);
					if (got.peak_level != want.peak_level)
						report_mismatch("peak_level", got.peak_level, want.peak_level);
					if (got.channel_changed != want.channel_changed)
						report_mismatch("channel_changed", got.channel_changed,
						                want.channel_changed);
					if (got.frame_changed != want.frame_changed)
						report_mismatch("frame_changed", got.frame_changed, want.frame_changed);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				// Always advance the predictor; a hand-typed row overrides its answer.
				predicted = advance_meter(in_ch.data);
				pending_readings.push_back(pin_flag ? pin_reading : predicted);
			end
		end
	end

	// Watchdog: end the run if no transaction moves on any channel for too long.
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Result side: draw a stall per result, then take it.
	initial begin : result_sink
		int unsigned stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(sink_idle_max);
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	initial begin : stimulus
		meter_step_t steps[$];
		int unsigned feed_pattern[NUM_PHASES] = '{15, 0, 3, 15, 0, 15, 3};
		int unsigned sink_pattern[NUM_PHASES] = '{15, 3, 0, 0, 15, 15, 3};
		level_t      hr;
		level_t      ds;
		level_t      mr;

		in_ch.valid   <= 1'b0;
		in_ch.data    <= '0;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.data   <= '0;
		pin_flag      <= 1'b0;
		pin_reading   <= '0;

		// Predictor reset: empty store, registers at their reset values.
		foreach (shown_mem[i]) begin
			shown_mem[i] = '0;
			peak_mem[i]  = '0;
			hold_mem[i]  = '0;
		end
		frame_acc        = 1'b0;
		hold_reload      = HOLD_RELOAD_RST;
		peak_decay_step  = PEAK_DECAY_STEP_RST;
		min_release_step = MIN_RELEASE_STEP_RST;

		// Directed table. Reset registers first: full-scale attack on an empty store,
		// a silent channel that only carries the frame flag, the top channel with an
		// invalid level closing the frame, then a fresh frame with nothing changed.
		steps.push_back(pinned_step(0, 8'd255, 1'b1, 1'b0, 8'd255, 8'd255, 1'b1, 1'b1));
		steps.push_back(pinned_step(1, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1));
		steps.push_back(pinned_step(15, 8'd128, 1'b0, 1'b1, 8'd0, 8'd0, 1'b0, 1'b1));
		steps.push_back(pinned_step(15, 8'd255, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0));
		// Release channel 0 to silence, run out its hold (hold-only updates leave
		// channel_changed low), then watch the peak decay; close the frame.
		for (int i = 0; i < 10; i++) begin
			steps.push_back(item_step(0, 8'd0, 1'b1, 1'b0));
		end
		steps.push_back(item_step(0, 8'd0, 1'b1, 1'b1));
		// Zero release step, full-size decay, no hold; also poke the unmapped index.
		steps.push_back(write_step(REG_MIN_RELEASE_STEP, 8'd0));
		steps.push_back(write_step(REG_PEAK_DECAY_STEP, 8'd255));
		steps.push_back(write_step(REG_HOLD_RELOAD, 8'd0));
		steps.push_back(write_step(REG_SPARE, 8'hA5));
		steps.push_back(item_step(2, 8'd2, 1'b1, 1'b0));
		steps.push_back(item_step(2, 8'd1, 1'b1, 1'b0));	// gap of one: level stays put
		steps.push_back(item_step(2, 8'd1, 1'b1, 1'b0));
		steps.push_back(item_step(0, 8'd0, 1'b1, 1'b0));	// decay saturates at zero
		steps.push_back(item_step(3, 8'd255, 1'b1, 1'b0));
		steps.push_back(item_step(3, 8'd254, 1'b1, 1'b1));
		// Long hold, no decay, release step large enough to snap to the target.
		steps.push_back(write_step(REG_HOLD_RELOAD, 8'd255));
		steps.push_back(write_step(REG_PEAK_DECAY_STEP, 8'd0));
		steps.push_back(write_step(REG_MIN_RELEASE_STEP, 8'd255));
		steps.push_back(item_step(4, 8'd200, 1'b1, 1'b0));
		steps.push_back(item_step(4, 8'd10, 1'b1, 1'b0));
		steps.push_back(item_step(4, 8'd77, 1'b0, 1'b1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].is_write) begin
				write_register(steps[i].wr.reg_index, steps[i].wr.wr_data);
			end else begin
				send_update(steps[i].item, steps[i].pinned, steps[i].want);
			end
		end

		// Random phases: all-zero and all-max registers, the reset values, then
		// random settings; the idle pattern of each side changes from phase to phase.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin hr = '0; ds = '0; mr = '0; end
				1: begin hr = '1; ds = '1; mr = '1; end
				2: begin
					hr = HOLD_RELOAD_RST;
					ds = PEAK_DECAY_STEP_RST;
					mr = MIN_RELEASE_STEP_RST;
				end
				default: begin
					// Keep the hold short most of the time so peaks actually decay.
					hr = ($urandom_range(0, 3) != 0) ? level_t'($urandom_range(0, 12))
					                                 : level_t'($urandom);
					ds = level_t'($urandom);
					mr = ($urandom_range(0, 1) != 0) ? level_t'($urandom_range(0, 8))
					                                 : level_t'($urandom);
				end
			endcase
			write_register(REG_HOLD_RELOAD, hr);
			write_register(REG_PEAK_DECAY_STEP, ds);
			write_register(REG_MIN_RELEASE_STEP, mr);
			feed_idle_max = feed_pattern[p];
			sink_idle_max = sink_pattern[p];
			run_random_phase(RANDOM_ITEMS, p == 3);
		end

		hold_feed_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_readings.size() != 0) begin
			report_mismatch("results never delivered", pending_readings.size(), 0);
		end
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
